/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/buh_pkg.sv */
// Shared types and constants of the bounded undo/redo history.
// No dependencies.
package buh_pkg;

  localparam int FIELD_W = 64;
  localparam int REQ_W   = 2;
  localparam int SEEK_W  = 6;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int LIMIT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_UNDO = 2'd1,
    REQ_REDO = 2'd2,
    REQ_SEEK = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_UNDO  = 2'd1,
    ST_NO_REDO  = 2'd2,
    ST_BAD_SEEK = 2'd3
  } status_t;

  // Per-item control passed from the state stage to the result stage.
  typedef struct packed {
    status_t status;
    logic    restore;
    logic    undo_avail;
    logic    redo_avail;
  } step_ctl_t;

endpackage

/* hdl/buh_store.sv */
// Snapshot memory: one write port, one read port with registered, enabled read data.
// No package dependencies.
module buh_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/bounded_undo_redo_history.sv */
// Bounded undo/redo history of snapshot pairs over a ring-buffer memory.
// Depends on buh_pkg, buh_store and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries one request (push, undo, redo,
//   seek) with the live metadata and parameter words and a seek index.
//   Output channel out_valid/out_stall returns one result per request:
//   status, restored or echoed words, rerender, cursor, count and the
//   undo/redo availability flags.
//   cfg_valid/cfg_ready writes history_limit; cfg_ready is always high.
//   Write it only while no request is in flight.
//   Pipeline: input register, state update with memory read, result
//   register. Throughput: one request per cycle while out_stall does not
//   hold a pending result; a restore right after a push needs no spacing
//   because the memory write lands before the next read.
//   Reset clears the history (no entries, cursor zero) and sets the limit
//   to 64. Memory contents are not cleared; no request can read an entry
//   that was never pushed.
//   When out_stall holds a pending result, the whole pipe freezes and
//   in_stall rises in the same cycle.
module bounded_undo_redo_history #(
  parameter int HISTORY_DEPTH = 64,
  parameter int WORD_BITS     = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [buh_pkg::LIMIT_W-1:0]   cfg_history_limit,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [buh_pkg::REQ_W-1:0]     in_req_type,
  input  logic [buh_pkg::FIELD_W-1:0]   in_meta_in,
  input  logic [buh_pkg::FIELD_W-1:0]   in_params_in,
  input  logic [buh_pkg::SEEK_W-1:0]    in_seek_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [buh_pkg::FIELD_W-1:0]   out_meta_out,
  output logic [buh_pkg::FIELD_W-1:0]   out_params_out,
  output logic                          out_rerender,
  output logic [buh_pkg::POS_W-1:0]     out_position,
  output logic [buh_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                          out_undo_available,
  output logic                          out_redo_available
);

  `include "assert_macros.svh"

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int XW = (CW > buh_pkg::LIMIT_W) ? CW : buh_pkg::LIMIT_W;
  localparam int SW = XW + 1;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [XW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(HISTORY_DEPTH)) begin
      sum = sum - SW'(HISTORY_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  // Architectural state
  logic [buh_pkg::LIMIT_W-1:0] limit_r;
  logic [PW-1:0]               oldest_r, oldest_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [PW-1:0]               cursor_r, cursor_nxt;

  // Input register
  logic                        v1_r;
  buh_pkg::req_t               s1_req_r;
  logic [WORD_BITS-1:0]        s1_meta_r;
  logic [WORD_BITS-1:0]        s1_par_r;
  logic [buh_pkg::SEEK_W-1:0]  s1_seek_r;

  // State stage outputs
  logic                        v2_r;
  buh_pkg::step_ctl_t          s2_ctl_r, s2_ctl_nxt;
  logic [WORD_BITS-1:0]        s2_meta_r;
  logic [WORD_BITS-1:0]        s2_par_r;
  logic [PW-1:0]               s2_pos_r;
  logic [CW-1:0]               s2_cnt_r;

  // Result register
  logic                        out_valid_r;
  buh_pkg::status_t            out_status_r;
  logic [WORD_BITS-1:0]        out_meta_r;
  logic [WORD_BITS-1:0]        out_par_r;
  logic                        out_rerender_r;
  logic [PW-1:0]               out_pos_r;
  logic [CW-1:0]               out_cnt_r;
  logic                        out_undo_r;
  logic                        out_redo_r;

  logic                        adv;
  logic                        step;
  logic                        fail;
  logic [XW-1:0]               cur_x, cnt_x, lim_x, lim_eff, n_x, n_new, target_x;
  logic [PW-1:0]               wr_slot, rd_slot;
  logic                        mem_wr_en, mem_rd_en;
  logic [2*WORD_BITS-1:0]      rd_word;
  logic [WORD_BITS-1:0]        rd_meta, rd_par;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign step      = adv && v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= buh_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_history_limit;
    end
  end

  // Cursor, count and ring arithmetic for the item in the input register.
  always_comb begin
    cur_x      = XW'(cursor_r);
    cnt_x      = XW'(count_r);
    lim_x      = XW'(limit_r);
    lim_eff    = lim_x;
    if (lim_x == '0) begin
      lim_eff = XW'(1);
    end else if (lim_x > XW'(HISTORY_DEPTH)) begin
      lim_eff = XW'(HISTORY_DEPTH);
    end
    n_x        = (cnt_x != '0) ? cur_x + XW'(1) : '0;
    n_new      = n_x;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    target_x   = '0;
    wr_slot    = wrap_add(oldest_r, n_x);
    mem_wr_en  = 1'b0;
    s2_ctl_nxt = '{status: buh_pkg::ST_OK, restore: 1'b0, undo_avail: 1'b0,
                   redo_avail: 1'b0};

    case (s1_req_r)
      buh_pkg::REQ_PUSH: begin
        if (n_x >= lim_eff) begin
          n_new      = lim_eff - XW'(1);
          oldest_nxt = wrap_add(oldest_r, n_x - lim_eff + XW'(1));
        end
        count_nxt  = CW'(n_new + XW'(1));
        cursor_nxt = PW'(n_new);
        mem_wr_en  = step;
      end
      buh_pkg::REQ_UNDO: begin
        if (cur_x == '0 || cnt_x == '0) begin
          s2_ctl_nxt.status = buh_pkg::ST_NO_UNDO;
        end else begin
          target_x           = cur_x - XW'(1);
          s2_ctl_nxt.restore = 1'b1;
        end
      end
      buh_pkg::REQ_REDO: begin
        if (cnt_x == '0 || cur_x + XW'(1) >= cnt_x) begin
          s2_ctl_nxt.status = buh_pkg::ST_NO_REDO;
        end else begin
          target_x           = cur_x + XW'(1);
          s2_ctl_nxt.restore = 1'b1;
        end
      end
      default: begin
        if (XW'(s1_seek_r) >= cnt_x) begin
          s2_ctl_nxt.status = buh_pkg::ST_BAD_SEEK;
        end else begin
          target_x           = XW'(s1_seek_r);
          s2_ctl_nxt.restore = 1'b1;
        end
      end
    endcase

    if (s2_ctl_nxt.restore) begin
      cursor_nxt = PW'(target_x);
    end
    rd_slot   = wrap_add(oldest_r, target_x);
    mem_rd_en = step && s2_ctl_nxt.restore;
    fail      = s2_ctl_nxt.status != buh_pkg::ST_OK;

    s2_ctl_nxt.undo_avail = cursor_nxt != '0;
    s2_ctl_nxt.redo_avail = (count_nxt != '0) &&
                            (XW'(cursor_nxt) + XW'(1) < XW'(count_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      cursor_r <= '0;
    end else if (step) begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  buh_store #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (2 * WORD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_slot),
    .wr_data ({s1_meta_r, s1_par_r}),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_slot),
    .rd_data (rd_word)
  );

  assign rd_meta = rd_word[2*WORD_BITS-1:WORD_BITS];
  assign rd_par  = rd_word[WORD_BITS-1:0];

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r       <= buh_pkg::req_t'(in_req_type);
      s1_meta_r      <= in_meta_in[WORD_BITS-1:0];
      s1_par_r       <= in_params_in[WORD_BITS-1:0];
      s1_seek_r      <= in_seek_index;
      s2_ctl_r       <= s2_ctl_nxt;
      s2_meta_r      <= s1_meta_r;
      s2_par_r       <= s1_par_r;
      s2_pos_r       <= cursor_nxt;
      s2_cnt_r       <= count_nxt;
      out_status_r   <= s2_ctl_r.status;
      out_meta_r     <= s2_ctl_r.restore ? rd_meta : s2_meta_r;
      out_par_r      <= s2_ctl_r.restore ? rd_par : s2_par_r;
      out_rerender_r <= s2_ctl_r.restore && (rd_par != s2_par_r);
      out_pos_r      <= s2_pos_r;
      out_cnt_r      <= s2_cnt_r;
      out_undo_r     <= s2_ctl_r.undo_avail;
      out_redo_r     <= s2_ctl_r.redo_avail;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_meta_out       = buh_pkg::FIELD_W'(out_meta_r);
  assign out_params_out     = buh_pkg::FIELD_W'(out_par_r);
  assign out_rerender       = out_rerender_r;
  assign out_position       = buh_pkg::POS_W'(out_pos_r);
  assign out_entry_count    = buh_pkg::COUNT_W'(out_cnt_r);
  assign out_undo_available = out_undo_r;
  assign out_redo_available = out_redo_r;

  `ASSERT_CLK(a_count_bound, count_r <= CW'(HISTORY_DEPTH), "entry count above depth")
  `ASSERT_CLK(a_cursor_range, (count_r != '0) |-> (XW'(cursor_r) < XW'(count_r)), "cursor past newest entry")
  `ASSERT_CLK(a_empty_cursor, (count_r == '0) |-> (cursor_r == '0), "cursor moved in empty history")
  `ASSERT_CLK(a_fail_holds, (step && fail) |=> ($stable(cursor_r) && $stable(count_r) && $stable(oldest_r)), "failed move changed state")

endmodule
